/* hdl/ffeq_pkg.sv */
`timescale 1ns / 1ps

package ffeq_pkg;

	// request codes on func
	localparam logic [1:0] FUNC_PIXEL  = 2'd0;
	localparam logic [1:0] FUNC_CALIB  = 2'd1;
	localparam logic [1:0] FUNC_TOGGLE = 2'd2;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam int FW_W       = 10;
	localparam int FH_W       = 9;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 10'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 9'd480;

	localparam int PIX_W    = 8;
	localparam int PIX_MAX  = 255;
	localparam int WIN_SIZE = 10;
	localparam int WIN_HALF = 5;

	// window sum and its division by 100: floor(s * 5243 / 2^19) is exact for s < 2^15
	localparam int SUM_W       = 15;
	localparam int RECIP_W     = 13;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

endpackage

/* hdl/frame_flat_field_equalizer.sv */
`timescale 1ns / 1ps
// A pixel request passes stage 1 (valid_s1) and the output register before it shows on out_valid.
// One request per cycle unless out_ready stalls; one frame memory access per pixel.
// Control requests (calibrate, toggle) are accepted like pixels but give no result.
// Reset (arst_n, async, active low) clears counters, mode flags, sum and average;
// the frame memory is not cleared and reads as zero until the first calibration ends.
module frame_flat_field_equalizer #(
	parameter int MAX_WIDTH  = 640,
	parameter int MAX_HEIGHT = 480
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [ffeq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ffeq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [ffeq_pkg::PIX_W-1:0]     pixel_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffeq_pkg::PIX_W-1:0]     pixel_out,
	output logic                           last_of_frame
);
	import ffeq_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = RW + WW;

	// configuration
	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	// control state
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             eq_on_q;
	logic             pending_q;
	logic             calibrating_q;
	logic             frame_eq_q;
	logic             ref_valid_q;
	logic [SUM_W-1:0] sum_q;
	logic [PIX_W-1:0] avg_q;
	logic             avg_load_q;

	// pipeline
	logic             valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             eq_s1;
	logic             last_s1;
	logic [PIX_W-1:0] ref_s1;
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             last_q;

	logic [PIX_W-1:0] ref_mem [DEPTH];

	logic             out_free;
	logic             advance;
	logic             accept;
	logic             is_pixel;
	logic [WW-1:0]    w;
	logic [HW-1:0]    h;
	logic [CW-1:0]    col;
	logic [RW-1:0]    row;
	logic             last_col;
	logic             last_row;
	logic             last;
	logic             frame_start;
	logic             cal_now;
	logic             feq;
	logic [PW-1:0]    row_base;
	logic [AW-1:0]    idx;
	logic [WW:0]      col_p5;
	logic [HW:0]      row_p5;
	logic [WW:0]      half_w;
	logic [HW:0]      half_h;
	logic             in_win;
	logic [SUM_W-1:0] sum_base;
	logic [SUM_W-1:0] sum_d;
	logic             mem_we;
	logic             mem_re;
	logic [SUM_W+RECIP_W-1:0] avg_prod;
	logic signed [PIX_W+1:0]  val;
	logic [PIX_W-1:0]         res;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign accept   = in_valid && in_ready;
	assign is_pixel = (func == FUNC_PIXEL);

	// effective size and clamped position
	always_comb begin
		if (frame_width_q == '0) begin
			w = WW'(1);
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h = HW'(1);
		end else if (int'(frame_height_q) > MAX_HEIGHT) begin
			h = HW'(MAX_HEIGHT);
		end else begin
			h = HW'(frame_height_q);
		end
		col = (col_q < w) ? col_q : CW'(w - WW'(1));
		row = (row_q < h) ? row_q : RW'(h - HW'(1));
		last_col    = (WW'(col) == w - WW'(1));
		last_row    = (HW'(row) == h - HW'(1));
		last        = last_col && last_row;
		frame_start = (col == '0) && (row == '0);
		cal_now     = calibrating_q || (frame_start && pending_q);
		feq         = frame_start ? (!pending_q && eq_on_q) : frame_eq_q;
		row_base    = PW'(row) * PW'(w);
		idx         = AW'(row_base) + AW'(col);
		// window test: w/2-5 <= col < w/2+5 and h/2-5 <= row < h/2+5, offset by 5 to stay unsigned
		half_w = (WW+1)'(w >> 1);
		half_h = (HW+1)'(h >> 1);
		col_p5 = (WW+1)'(col) + (WW+1)'(WIN_HALF);
		row_p5 = (HW+1)'(row) + (HW+1)'(WIN_HALF);
		in_win = (col_p5 >= half_w) && (col_p5 < half_w + (WW+1)'(WIN_SIZE)) &&
			(row_p5 >= half_h) && (row_p5 < half_h + (HW+1)'(WIN_SIZE));
		sum_base = (frame_start && pending_q) ? '0 : sum_q;
		sum_d    = sum_base + (in_win ? SUM_W'(pixel_in) : '0);
	end

	assign mem_we = accept && is_pixel && cal_now;
	assign mem_re = accept && is_pixel && !cal_now;

	// frame memory: one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ref_mem[idx] <= pixel_in;
		end
		if (mem_re) begin
			ref_s1 <= ref_mem[idx];
		end
	end

	assign avg_prod = SUM_W'(sum_q) * RECIP_100;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			col_q          <= '0;
			row_q          <= '0;
			eq_on_q        <= 1'b0;
			pending_q      <= 1'b0;
			calibrating_q  <= 1'b0;
			frame_eq_q     <= 1'b0;
			ref_valid_q    <= 1'b0;
			sum_q          <= '0;
			avg_q          <= '0;
			avg_load_q     <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  frame_width_q  <= FW_W'(cfg_data);
					REG_FRAME_HEIGHT: frame_height_q <= FH_W'(cfg_data);
					default: ;
				endcase
			end
			avg_load_q <= mem_we && last;
			// average is registered from the sum via avg_load_q after the calibration frame ends
			if (avg_load_q) begin
				avg_q <= PIX_W'(avg_prod >> RECIP_SHIFT);
			end
			if (accept) begin
				case (func)
					FUNC_CALIB: begin
						pending_q <= 1'b1;
						eq_on_q   <= 1'b0;
					end
					FUNC_TOGGLE: begin
						eq_on_q   <= !eq_on_q;
						pending_q <= 1'b0;
					end
					FUNC_PIXEL: begin
						if (frame_start) begin
							frame_eq_q <= feq;
							if (pending_q) begin
								pending_q <= 1'b0;
							end
						end
						if (cal_now) begin
							sum_q         <= sum_d;
							calibrating_q <= !last;
							if (last) begin
								ref_valid_q <= 1'b1;
								eq_on_q     <= 1'b1;
							end
						end
						if (last_col) begin
							col_q <= '0;
							row_q <= last_row ? '0 : row + RW'(1);
						end else begin
							col_q <= col + CW'(1);
							row_q <= row;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// stage 1 and output valid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= accept && is_pixel;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pixel) begin
			pix_s1  <= pixel_in;
			eq_s1   <= !cal_now && feq;
			last_s1 <= last;
		end
		if (advance) begin
			pixel_out_q <= res;
			last_q      <= last_s1;
		end
	end

	always_comb begin
		val = $signed({2'b00, pix_s1})
			- $signed({2'b00, ref_valid_q ? ref_s1 : {PIX_W{1'b0}}})
			+ $signed({2'b00, ref_valid_q ? avg_q : {PIX_W{1'b0}}});
		if (!eq_s1) begin
			res = pix_s1;
		end else if (val < 0) begin
			res = '0;
		end else if (val > (PIX_W+2)'(PIX_MAX)) begin
			res = PIX_W'(PIX_MAX);
		end else begin
			res = PIX_W'(val);
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign last_of_frame = last_q;

	// memory port serves either a write or a read in a cycle
	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame memory read and write in the same cycle");

	a_cal_end: assert property (@(posedge clk) disable iff (!arst_n)
		avg_load_q |-> ref_valid_q && !calibrating_q)
		else $error("average load without a finished calibration");

	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_pixel && last |=> col_q == '0 && row_q == '0)
		else $error("position did not wrap after last pixel");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(pix_s1) && $stable(ref_s1))
		else $error("stalled stage 1 lost its pixel");

endmodule
